>>> hdl/gsa_pkg.sv
// Package for the generational slot allocator: codes, states and the
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package gsa_pkg;

    localparam int NUM_REGS = 8;
    localparam int REG_W    = 4;

    typedef enum logic [2:0] {
        MODE_ALLOC   = 3'd0,
        MODE_ALLOCAT = 3'd1,
        MODE_LOOKUP  = 3'd2,
        MODE_RELEASE = 3'd3,
        MODE_CLEAR   = 3'd4,
        MODE_COUNT   = 3'd5,
        MODE_NOP6    = 3'd6,
        MODE_NOP7    = 3'd7
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_NOFREE = 3'd1,
        ST_RANGE  = 3'd2,
        ST_BUSY   = 3'd3,
        ST_STALE  = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_READ,
        S_DECIDE,
        S_CLEAR,
        S_OUT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;       // capture the input transaction
        logic scan_init;  // set scan pointer to start
        logic scan_step;  // advance scan pointer
        logic rd;         // issue payload memory read for the target slot
        logic decide;     // evaluate and commit the operation
        logic clr_step;   // clear one category of active flags
        logic out_load;   // result register captures
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] mode;
        logic       scan_done;
        logic       clr_done;
    } sts_t;

endpackage

>>> hdl/gsa_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
module gsa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hdl/gsa_ctrl.sv
// Controller state machine of the slot allocator.
// Depends on gsa_pkg.
`timescale 1ns / 1ps
module gsa_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  gsa_pkg::sts_t sts,
    output gsa_pkg::cmd_t cmd
);
    import gsa_pkg::*;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    case (mode_t'(sts.mode))
                        MODE_ALLOC: state_next = S_SCAN;
                        MODE_COUNT: state_next = S_SCAN;
                        MODE_CLEAR: state_next = S_CLEAR;
                        default:    state_next = S_READ;
                    endcase
                end
            end
            S_SCAN:   state_next = sts.scan_done ? S_READ : S_SCAN;
            S_READ:   state_next = S_DECIDE;
            S_DECIDE: state_next = S_OUT;
            S_CLEAR:  state_next = sts.clr_done ? S_OUT : S_CLEAR;
            S_OUT:    state_next = (!ov_reg || out_ready) ? S_IDLE : S_OUT;
            default:  state_next = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd = '0;
        in_ready = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE: begin
                cmd.load = in_valid;
                cmd.scan_init = in_valid;
            end
            S_SCAN:  cmd.scan_step = !sts.scan_done;
            S_READ:  cmd.rd = 1'b1;
            S_DECIDE: cmd.decide = 1'b1;
            S_CLEAR: cmd.clr_step = 1'b1;
            S_OUT:   cmd.out_load = !ov_reg || out_ready;
            default: cmd = '0;
        endcase
    end

    always_comb begin
        ov_next = ov_reg;
        if (out_ready) ov_next = 1'b0;
        if (cmd.out_load) ov_next = 1'b1;
    end

    assign out_valid = ov_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end
endmodule

>>> hdl/gsa_dp.sv
// Datapath of the slot allocator: config registers, slot flags, payload and
// generation RAM, scan pointer and result register.
// Depends on gsa_pkg and gsa_ram.
`timescale 1ns / 1ps
module gsa_dp #(
    parameter int BAND_SLOTS     = 16,
    parameter int CATEGORY_COUNT = 4,
    parameter int GEN_BITS       = 8
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_addr,
    input  logic [3:0]    cfg_wdata,
    input  logic [103:0]  in_data,
    input  gsa_pkg::cmd_t cmd,
    output gsa_pkg::sts_t sts,
    output logic [127:0]  out_data
);
    import gsa_pkg::*;

    // Bands are padded to a power of two so the slot address is {band, slot}
    localparam int SB    = (BAND_SLOTS > 1) ? $clog2(BAND_SLOTS) : 1;
    localparam int NSLOT = 4 << SB;
    localparam int AB    = SB + 2;
    localparam int CW    = (SB + 1 > 5) ? SB + 1 : 5;
    localparam int PW    = 16 + 16 + 16 + 16 + 1 + 1 + 16;
    localparam int RW    = PW + GEN_BITS;

    // Configuration registers
    logic [REG_W-1:0] cfg_reg [NUM_REGS];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg[0] <= 4'd7;  cfg_reg[1] <= 4'd11;
            cfg_reg[2] <= 4'd2;  cfg_reg[3] <= 4'd15;
            cfg_reg[4] <= 4'd0;  cfg_reg[5] <= 4'd15;
            cfg_reg[6] <= 4'd0;  cfg_reg[7] <= 4'd15;
        end else if (cfg_we) begin
            cfg_reg[cfg_addr] <= cfg_wdata;
        end
    end

    // Captured input transaction
    logic [103:0] in_reg;
    always_ff @(posedge aclk) begin
        if (cmd.load) in_reg <= in_data;
    end
    logic [2:0]  mode;
    logic [1:0]  cat;
    logic [7:0]  slot_in, gen_in;
    assign mode    = in_reg[2:0];
    assign cat     = in_reg[4:3];
    assign slot_in = in_reg[12:5];
    assign gen_in  = in_reg[20:13];
    assign sts.mode = cmd.load ? in_data[2:0] : mode;

    logic cat_ok;
    assign cat_ok = ({30'd0, cat} < CATEGORY_COUNT);

    // Active flags; wr_reg marks slots whose RAM word has been written
    logic [NSLOT-1:0]    act_reg;
    logic [NSLOT-1:0]    wr_reg;

    // Scan over the band
    logic [CW-1:0] ptr_reg, last_c;
    logic [4:0]    cnt_reg;
    logic          found_reg;
    logic [SB-1:0] hit_reg;
    logic [3:0]    first_r, last_r;
    assign first_r = cfg_reg[{1'b0, cat} << 1];
    assign last_r  = cfg_reg[({1'b0, cat} << 1) + 3'd1];
    always_comb begin
        if (32'(last_r) > BAND_SLOTS - 1)
            last_c = CW'(BAND_SLOTS - 1);
        else
            last_c = CW'(last_r);
    end
    logic [CW-1:0] scan_end;
    assign scan_end = (mode == MODE_COUNT) ? CW'(BAND_SLOTS - 1) : last_c;

    logic [AB-1:0] scan_addr;
    assign scan_addr = {cat, ptr_reg[SB-1:0]};
    logic          cur_act;
    assign cur_act = act_reg[scan_addr];

    logic in_band;
    assign in_band = ({1'b0, ptr_reg} <= {1'b0, scan_end}) && cat_ok
                     && (32'(ptr_reg) < BAND_SLOTS);
    assign sts.scan_done = !in_band || (mode == MODE_ALLOC && found_reg);

    // Clear pointer over categories
    logic [1:0] clr_reg;
    assign sts.clr_done = (clr_reg == 2'd3);

    always_ff @(posedge aclk) begin
        if (cmd.scan_init) begin
            ptr_reg   <= (in_data[2:0] == MODE_COUNT) ? '0
                         : CW'(cfg_reg[{1'b0, in_data[4:3]} << 1]);
            cnt_reg   <= '0;
            found_reg <= 1'b0;
            clr_reg   <= '0;
        end else if (cmd.scan_step) begin
            if (!cur_act && mode == MODE_ALLOC) begin
                found_reg <= 1'b1;
                hit_reg   <= ptr_reg[SB-1:0];
            end else begin
                ptr_reg <= ptr_reg + 1'b1;
            end
            if (cur_act && cnt_reg != 5'd31) cnt_reg <= cnt_reg + 1'b1;
        end else if (cmd.clr_step) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // Target slot
    logic [SB-1:0] tgt;
    logic          slot_ok;
    assign slot_ok = ({24'd0, slot_in} < BAND_SLOTS);
    assign tgt = (mode == MODE_ALLOC) ? hit_reg : slot_in[SB-1:0];
    logic [AB-1:0] taddr;
    assign taddr = {cat, tgt};

    // Payload and generation RAM
    logic          ram_we;
    logic [RW-1:0] ram_wd, ram_rd;
    gsa_ram #(.WIDTH(RW), .DEPTH(NSLOT)) u_pay (
        .aclk(aclk), .we(ram_we), .waddr(taddr), .wdata(ram_wd),
        .raddr(taddr), .rdata(ram_rd)
    );
    // fields: id, room, x, y, pos, cond, src, generation (low to high);
    // a never-written slot reads as zero
    logic [GEN_BITS-1:0] gcur, gnew;
    assign gcur = wr_reg[taddr] ? ram_rd[PW +: GEN_BITS] : '0;
    always_comb begin
        gnew = gcur + 1'b1;
        if (gnew == '0) gnew = GEN_BITS'(1);
    end

    logic          ok;
    logic [2:0]    st;
    logic          take, rel;
    always_comb begin
        st = ST_OK; take = 1'b0; rel = 1'b0;
        case (mode_t'(mode))
            MODE_ALLOC: begin
                if (!cat_ok) st = ST_RANGE;
                else if (!found_reg) st = ST_NOFREE;
                else take = 1'b1;
            end
            MODE_ALLOCAT: begin
                if (!cat_ok || !slot_ok) st = ST_RANGE;
                else if (act_reg[taddr]) st = ST_BUSY;
                else take = 1'b1;
            end
            MODE_LOOKUP, MODE_RELEASE: begin
                if (!cat_ok || !slot_ok) st = ST_RANGE;
                else if (!act_reg[taddr] || 32'(gcur) != 32'(gen_in)) st = ST_STALE;
                else rel = (mode == MODE_RELEASE);
            end
            default: st = ST_OK;
        endcase
    end
    assign ok = (st == ST_OK);

    assign ram_we = cmd.decide && take;
    always_comb begin
        ram_wd = wr_reg[taddr] ? ram_rd : '0;
        ram_wd[15:0]  = in_reg[36:21];
        ram_wd[31:16] = in_reg[52:37];
        if (mode == MODE_ALLOC) begin
            ram_wd[47:32] = in_reg[68:53];
            ram_wd[63:48] = in_reg[84:69];
            ram_wd[64]    = in_reg[85];
            ram_wd[65]    = in_reg[86];
            ram_wd[81:66] = in_reg[102:87];
        end else begin
            ram_wd[64] = 1'b0;
            ram_wd[65] = 1'b0;
        end
        ram_wd[PW +: GEN_BITS] = gnew;
    end

    // Flag update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= '0;
            wr_reg  <= '0;
        end else if (cmd.decide) begin
            if (take) begin
                act_reg[taddr] <= 1'b1;
                wr_reg[taddr]  <= 1'b1;
            end else if (rel) begin
                act_reg[taddr] <= 1'b0;
            end
        end else if (cmd.clr_step) begin
            for (int i = 0; i < BAND_SLOTS; i++)
                act_reg[AB'({clr_reg, SB'(i)})] <= 1'b0;
        end
    end

    // Result register; packing status, slot, gen, payload, count
    logic [127:0] res_reg, res_next;
    always_comb begin
        res_next = '0;
        res_next[2:0] = st;
        if (ok && (take || mode == MODE_LOOKUP || mode == MODE_RELEASE)) begin
            res_next[6:3]  = 4'(tgt);
            res_next[14:7] = take ? 8'(gnew) : 8'(gcur);
        end
        if (ok && mode == MODE_LOOKUP) res_next[96:15] = ram_rd[PW-1:0];
        if (mode == MODE_COUNT) res_next[101:97] = cat_ok ? cnt_reg : 5'd0;
        if (mode == MODE_CLEAR || mode == MODE_NOP6 || mode == MODE_NOP7)
            res_next = '0;
    end
    logic [127:0] hold_reg;
    always_ff @(posedge aclk) begin
        if (cmd.decide || cmd.clr_step) hold_reg <= (cmd.clr_step ? 128'd0 : res_next);
        if (cmd.out_load) res_reg <= hold_reg;
    end
    assign out_data = res_reg;
endmodule

>>> hdl/generational_slot_allocator.sv
// Generational slot allocator: one result per input transaction.
// Allocate-at, lookup, release and unused modes pass S_READ, S_DECIDE and S_OUT;
// allocate and count first scan the band serially in S_SCAN, and clear steps
// through the categories in S_CLEAR. s_tready rises in the same cycle as
// m_tvalid; a held result stalls the next transaction in its last stage.
// Sync active-low reset clears flags, generations, control; loads config defaults.
`timescale 1ns / 1ps
module generational_slot_allocator #(
    parameter int BAND_SLOTS     = 16,
    parameter int CATEGORY_COUNT = 4,
    parameter int GEN_BITS       = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [3:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // mode, category, slot, generation, identity, room, local_x, local_y,
    // positioned, conditional, source_index
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, out_slot, out_generation, out_identity, out_room, out_local_x,
    // out_local_y, out_positioned, out_conditional, out_source_index,
    // active_total
    output logic [103:0] m_tdata
);
    import gsa_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic [127:0] od;

    gsa_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .sts(sts), .cmd(cmd)
    );

    gsa_dp #(
        .BAND_SLOTS(BAND_SLOTS),
        .CATEGORY_COUNT(CATEGORY_COUNT),
        .GEN_BITS(GEN_BITS)
    ) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
        .cfg_wdata(cfg_wdata), .in_data(s_tdata), .cmd(cmd), .sts(sts),
        .out_data(od)
    );

    assign m_tdata = od[103:0];
endmodule
